// ===== hw/rtl/lepn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lepn_pkg;

	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int FULL_SCALE_DEF    = 1000;
	localparam int POS_WIDTH         = 11;
	localparam int APB_ADDR_W        = 4;
	localparam int APB_DATA_W        = 32;

	// tolerance is 30 percent of the span, kept as the reduced ratio 3/10
	localparam int TOL_NUM           = 3;
	localparam int TOL_DEN           = 10;
	localparam int TOL_MIN           = 200;
	localparam int REGION_MARGIN     = 300;

	localparam int DIV_BITS_PER_STG  = 4;

	localparam int WHITE_RESET       = 500;
	localparam int BLACK_RESET       = 3500;
	localparam int EDGE_RESET        = 2000;
	localparam int BARCODE_RESET     = 3500;

	typedef enum logic [1:0] {
		REG_WHITE   = 2'd0,
		REG_BLACK   = 2'd1,
		REG_EDGE    = 2'd2,
		REG_BARCODE = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		REGION_EDGE   = 2'd0,
		REGION_DARK   = 2'd1,
		REGION_LIGHT  = 2'd2,
		REGION_SEARCH = 2'd3
	} region_t;

	// per-item flags that ride alongside the divider
	typedef struct packed {
		logic    below;
		logic    full;
		logic    on_edge;
		region_t region;
		logic    barcode;
	} side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lepn_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lepn_div_pipe import lepn_pkg::*; #(
	parameter int DVS_W     = SAMPLE_BITS_DEF,
	parameter int QUO_W     = 10,
	parameter int PER_STAGE = DIV_BITS_PER_STG
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  wire                     in_vld,
	input  wire [DVS_W+QUO_W-1:0]   dividend,
	input  wire [DVS_W-1:0]         divisor,
	input  wire side_t              in_side,
	output logic                    out_vld,
	output logic [QUO_W-1:0]        quotient,
	output side_t                   out_side
);

	localparam int NST = (QUO_W + PER_STAGE - 1) / PER_STAGE;
	localparam int TB  = NST * PER_STAGE;
	localparam int XW  = DVS_W + TB;

	// dividend / 2^QUO_W is below the divisor, so the quotient fits QUO_W bits
	logic [XW-1:0]    dvd_x;
	logic [DVS_W-1:0] rem_s [NST+1];
	logic [TB-1:0]    low_s [NST+1];
	logic [DVS_W-1:0] dvs_s [NST+1];
	side_t            side_s [NST+1];
	logic             vld_s [NST+1];

	assign dvd_x     = XW'(dividend);
	assign rem_s[0]  = dvd_x[XW-1:TB];
	assign low_s[0]  = dvd_x[TB-1:0];
	assign dvs_s[0]  = divisor;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar g = 0; g < NST; g++) begin : g_stg
		logic [DVS_W-1:0] rem_nxt;
		logic [TB-1:0]    low_nxt;

		always_comb begin
			logic [DVS_W:0]   t;
			logic [DVS_W-1:0] r;
			logic [TB-1:0]    l;
			r = rem_s[g];
			l = low_s[g];
			t = '0;
			for (int k = 0; k < PER_STAGE; k++) begin
				t = {r, l[TB-1]};
				l = {l[TB-2:0], 1'b0};
				if (t >= {1'b0, dvs_s[g]}) begin
					t    = t - {1'b0, dvs_s[g]};
					l[0] = 1'b1;
				end
				r = t[DVS_W-1:0];
			end
			rem_nxt = r;
			low_nxt = l;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= rem_nxt;
				low_s[g+1]  <= low_nxt;
				dvs_s[g+1]  <= dvs_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[NST];
	assign quotient = low_s[NST][QUO_W-1:0];
	assign out_side = side_s[NST];

endmodule

`default_nettype wire

// ===== hw/rtl/line_edge_position_normalizer.sv =====
// stages: decision register, full-scale product, divider stages, output register
// throughput: one transfer per cycle; the divider retires 4 quotient bits per stage
// all stages advance together, held only while the output register waits on out_ready
// reset clears every valid bit and loads the calibration registers with their defaults
`timescale 1ns / 1ps
`default_nettype none

module line_edge_position_normalizer import lepn_pkg::*; #(
	parameter int POSITION_FULL_SCALE = FULL_SCALE_DEF,
	parameter int SAMPLE_BITS         = SAMPLE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,

	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [SAMPLE_BITS-1:0]        line_sample,
	input  wire [SAMPLE_BITS-1:0]        barcode_sample,

	output logic                         out_valid,
	input  wire                          out_ready,
	output logic signed [POS_WIDTH-1:0]  position,
	output logic                         on_edge,
	output logic [1:0]                   region,
	output logic                         barcode_seen,

	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [APB_ADDR_W-1:0]         paddr,
	input  wire [APB_DATA_W-1:0]         pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready
);

	localparam int SB  = SAMPLE_BITS;
	localparam int QW  = $clog2(POSITION_FULL_SCALE + 1);
	localparam int PW  = (QW > POS_WIDTH) ? QW : POS_WIDTH;
	localparam int CW  = ((SB > 10) ? SB : 10) + 2;
	localparam int TW  = SB + 5;
	localparam int MW  = SB + QW;

	// calibration registers
	logic [SB-1:0] white_q, black_q, edge_q, barcode_q;
	reg_idx_t      widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q   <= SB'(WHITE_RESET);
			black_q   <= SB'(BLACK_RESET);
			edge_q    <= SB'(EDGE_RESET);
			barcode_q <= SB'(BARCODE_RESET);
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_WHITE:   white_q   <= pwdata[SB-1:0];
				REG_BLACK:   black_q   <= pwdata[SB-1:0];
				REG_EDGE:    edge_q    <= pwdata[SB-1:0];
				REG_BARCODE: barcode_q <= pwdata[SB-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_WHITE:   prdata = APB_DATA_W'(white_q);
			REG_BLACK:   prdata = APB_DATA_W'(black_q);
			REG_EDGE:    prdata = APB_DATA_W'(edge_q);
			REG_BARCODE: prdata = APB_DATA_W'(barcode_q);
			default:     prdata = '0;
		endcase
	end

	// whole pipe moves when the output register is free or being drained
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// stage 1: branch select, range, edge, region and barcode decisions
	logic          below;
	logic [SB-1:0] num, diff, span;
	logic [CW-1:0] rng;
	logic          rng_empty, rng_sat;
	logic [TW-1:0] tol_lhs, tol_rhs;
	logic          edge_hit;
	logic [CW-1:0] s_x, thr_x;
	region_t       reg_c;
	side_t         side_c;

	always_comb begin
		s_x   = CW'(line_sample);
		thr_x = CW'(edge_q);
		below = line_sample < edge_q;
		diff  = below ? (edge_q - line_sample) : (line_sample - edge_q);
		num   = diff;
		rng   = below ? (thr_x - CW'(white_q)) : (CW'(black_q) - thr_x);
		// range is zero or negative when its sign bit is set or it is all zero
		rng_empty = rng[CW-1] || (rng == '0);
		rng_sat   = !rng_empty && (CW'(num) >= rng);
		span  = (black_q >= white_q) ? (black_q - white_q) : (white_q - black_q);
		// diff < floor(3*span/10) is the same as 10*(diff+1) <= 3*span
		tol_lhs  = (TW'(diff) + TW'(1)) * TW'(TOL_DEN);
		tol_rhs  = TW'(span) * TW'(TOL_NUM);
		edge_hit = (tol_lhs <= tol_rhs) || (CW'(diff) < CW'(TOL_MIN));
		if (edge_hit)
			reg_c = REGION_EDGE;
		else if (s_x > thr_x + CW'(REGION_MARGIN))
			reg_c = REGION_DARK;
		else if (s_x + CW'(REGION_MARGIN) < thr_x)
			reg_c = REGION_LIGHT;
		else
			reg_c = REGION_SEARCH;
		side_c.below   = below;
		side_c.full    = rng_empty || rng_sat;
		side_c.on_edge = edge_hit;
		side_c.region  = reg_c;
		side_c.barcode = barcode_sample > barcode_q;
	end

	logic          valid_s1, valid_s2;
	logic [SB-1:0] num_s1, dvs_s1, dvs_s2;
	logic [MW-1:0] prod_s2;
	side_t         side_s1, side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1  <= num;
			dvs_s1  <= rng[SB-1:0];
			side_s1 <= side_c;
			// stage 2: scale by full scale
			prod_s2 <= MW'(num_s1) * MW'(POSITION_FULL_SCALE);
			dvs_s2  <= dvs_s1;
			side_s2 <= side_s1;
		end
	end

	// stages 3 onward: quotient bits
	logic          div_vld;
	logic [QW-1:0] quo;
	side_t         div_side;

	lepn_div_pipe #(
		.DVS_W     (SB),
		.QUO_W     (QW),
		.PER_STAGE (DIV_BITS_PER_STG)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (valid_s2),
		.dividend (prod_s2),
		.divisor  (dvs_s2),
		.in_side  (side_s2),
		.out_vld  (div_vld),
		.quotient (quo),
		.out_side (div_side)
	);

	// output register: saturate, apply sign, fold to the field width
	logic [PW-1:0]        mag;
	logic [PW-1:0]        pos_w;
	logic [POS_WIDTH-1:0] pos_q;
	logic                 on_edge_q, barcode_q_o;
	region_t              region_q;

	assign mag   = div_side.full ? PW'(POSITION_FULL_SCALE) : PW'(quo);
	assign pos_w = div_side.below ? mag : (PW'(0) - mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q       <= pos_w[POS_WIDTH-1:0];
			on_edge_q   <= div_side.on_edge;
			region_q    <= div_side.region;
			barcode_q_o <= div_side.barcode;
		end
	end

	assign out_valid    = out_valid_q;
	assign position     = $signed(pos_q);
	assign on_edge      = on_edge_q;
	assign region       = region_q;
	assign barcode_seen = barcode_q_o;

endmodule

`default_nettype wire

// ===== hw/rtl/lepn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lepn_checker import lepn_pkg::*; #(
	parameter int FULL_SCALE = FULL_SCALE_DEF
) (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_ready,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire signed [POS_WIDTH-1:0]  position,
	input wire                         on_edge,
	input wire [1:0]                   region,
	input wire                         barcode_seen
);

	localparam int POS_MAX = (1 << (POS_WIDTH - 1)) - 1;

	// a result that is not taken stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(on_edge)
			&& $stable(region) && $stable(barcode_seen))
		else $error("stalled result changed");

	// an empty output register never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with output register empty");

	// region code zero exactly when the edge flag is set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (on_edge == (region == REGION_EDGE)))
		else $error("region and on_edge disagree");

	// position saturates to full scale when that fits the field
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (FULL_SCALE <= POS_MAX) |->
			(position <= FULL_SCALE) && (position >= -FULL_SCALE))
		else $error("position beyond full scale");

endmodule

bind line_edge_position_normalizer lepn_checker #(
	.FULL_SCALE (POSITION_FULL_SCALE)
) u_lepn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.position     (position),
	.on_edge      (on_edge),
	.region       (region),
	.barcode_seen (barcode_seen)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import lepn_pkg::*;

	localparam int FULL_SCALE = FULL_SCALE_DEF;
	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS_DEF) - 1;
	localparam int TOL_PCT = 30;
	localparam int PCT_BASE = 100;
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] position;
		logic                        on_edge;
		region_t                     region;
		logic                        barcode_seen;
	} reading_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [SAMPLE_BITS_DEF-1:0] line_sample;
	logic [SAMPLE_BITS_DEF-1:0] barcode_sample;
	logic out_valid;
	logic out_ready;
	logic signed [POS_WIDTH-1:0] position;
	logic on_edge;
	logic [1:0] region;
	logic barcode_seen;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// calibration as the block should hold it
	logic [SAMPLE_BITS_DEF-1:0] cal_white = SAMPLE_BITS_DEF'(WHITE_RESET);
	logic [SAMPLE_BITS_DEF-1:0] cal_black = SAMPLE_BITS_DEF'(BLACK_RESET);
	logic [SAMPLE_BITS_DEF-1:0] cal_edge = SAMPLE_BITS_DEF'(EDGE_RESET);
	logic [SAMPLE_BITS_DEF-1:0] cal_barcode = SAMPLE_BITS_DEF'(BARCODE_RESET);

	reading_t expected_readings[$];
	int mismatch_count = 0;
	bit tx_burst = 0;
	bit rx_burst = 0;
	int rx_hold_cycles = 0;

	line_edge_position_normalizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.line_sample   (line_sample),
		.barcode_sample(barcode_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.position      (position),
		.on_edge       (on_edge),
		.region        (region),
		.barcode_seen  (barcode_seen),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic reading_t predict_reading(int line, int bc);
		int s;
		int thr;
		int wht;
		int blk;
		int span_w;
		int p;
		int diff;
		int span;
		int tol;
		reading_t r;
		s = line;
		thr = int'(cal_edge);
		wht = int'(cal_white);
		blk = int'(cal_black);
		if (s < thr) begin
			span_w = thr - wht;
			p = (span_w > 0) ? ((thr - s) * FULL_SCALE) / span_w : FULL_SCALE;
		end else begin
			span_w = blk - thr;
			p = (span_w > 0) ? -(((s - thr) * FULL_SCALE) / span_w) : -FULL_SCALE;
		end
		if (p > FULL_SCALE) p = FULL_SCALE;
		if (p < -FULL_SCALE) p = -FULL_SCALE;
		diff = (s < thr) ? thr - s : s - thr;
		span = (blk < wht) ? wht - blk : blk - wht;
		tol = span * TOL_PCT / PCT_BASE;
		if (tol < TOL_MIN) tol = TOL_MIN;
		r.position = p[POS_WIDTH-1:0];
		r.on_edge = (diff < tol);
		// thr - margin may go negative, the compare stays signed
		if (r.on_edge) r.region = REGION_EDGE;
		else if (s > thr + REGION_MARGIN) r.region = REGION_DARK;
		else if (s < thr - REGION_MARGIN) r.region = REGION_LIGHT;
		else r.region = REGION_SEARCH;
		r.barcode_seen = (bc > int'(cal_barcode));
		return r;
	endfunction

	function automatic int clamp_sample(int v);
		if (v < 0) return 0;
		if (v > SAMPLE_MAX) return SAMPLE_MAX;
		return v;
	endfunction

	function automatic int pick_line();
		int sel;
		int v;
		sel = $urandom_range(0, 9);
		if (sel < 4) v = $urandom_range(0, SAMPLE_MAX);
		else if (sel < 8) v = int'(cal_edge) + $urandom_range(0, 2400) - 1200;
		else if (sel == 8) begin
			v = ($urandom_range(0, 1) ? int'(cal_white) : int'(cal_black));
			v = v + $urandom_range(0, 100) - 50;
		end else v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
		return clamp_sample(v);
	endfunction

	function automatic int pick_barcode();
		if ($urandom_range(0, 1))
			return clamp_sample(int'(cal_barcode) + $urandom_range(0, 6) - 3);
		return int'($urandom_range(0, SAMPLE_MAX));
	endfunction

	// sender: valid stays up between back-to-back transfers
	task automatic send_sample(int line, int bc);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		line_sample <= SAMPLE_BITS_DEF'(line);
		barcode_sample <= SAMPLE_BITS_DEF'(bc);
		do @(posedge clk); while (in_ready !== 1'b1);
		expected_readings.push_back(predict_reading(line, bc));
	endtask

	task automatic send_random(int count);
		repeat (count) send_sample(pick_line(), pick_barcode());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_readings.size() != 0);
	endtask

	task automatic write_cal(reg_idx_t idx, int val);
		logic [APB_DATA_W-1:0] junk;
		logic [SAMPLE_BITS_DEF-1:0] v12;
		junk = $urandom();
		v12 = SAMPLE_BITS_DEF'(val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// upper bits are noise, the block keeps only the sample width
		pwdata <= {junk[APB_DATA_W-1:SAMPLE_BITS_DEF], v12};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_WHITE:   cal_white = v12;
			REG_BLACK:   cal_black = v12;
			REG_EDGE:    cal_edge = v12;
			REG_BARCODE: cal_barcode = v12;
			default:     ;
		endcase
		// read the register back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== APB_DATA_W'(v12)) begin
			$error("prdata: expected %0d, actual %0d", v12, prdata);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all_cal(int w, int b, int e, int bc);
		write_cal(REG_WHITE, w);
		write_cal(REG_BLACK, b);
		write_cal(REG_EDGE, e);
		write_cal(REG_BARCODE, bc);
	endtask

	task automatic test_reset_calibration();
		// defaults: tolerance 900, region margins at 1700 and 2300
		send_sample(0, 0);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(2000, 3500);
		send_sample(2001, 3501);
		send_sample(1999, 3499);
		send_sample(500, 0);
		send_sample(3500, 4095);
		send_sample(1101, 100);
		send_sample(1100, 100);
		send_sample(2899, 100);
		send_sample(2900, 100);
		send_sample(1700, 100);
		send_sample(1699, 100);
		send_sample(2300, 100);
		send_sample(2301, 100);
		drain();
	endtask

	task automatic test_empty_ranges();
		// threshold at or below white and black at or below threshold
		write_all_cal(2500, 1500, 2000, 0);
		send_sample(0, 1);
		send_sample(1999, 0);
		send_sample(2000, 0);
		drain();
		// zero threshold pushes the light bound negative, zero span
		write_all_cal(0, 0, 0, 0);
		send_sample(0, 0);
		send_sample(199, 1);
		send_sample(200, 2);
		send_sample(301, 3);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		drain();
		write_all_cal(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
		send_sample(0, 0);
		send_sample(3794, 4094);
		send_sample(3795, 4094);
		drain();
	endtask

	task automatic test_random_calibrations();
		int w;
		int b;
		int e;
		int bc;
		int sel;
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0) begin
				w = 0; b = SAMPLE_MAX; e = 2048; bc = 0;
			end else if (ph == 1) begin
				w = SAMPLE_MAX; b = 0; e = SAMPLE_MAX; bc = SAMPLE_MAX;
			end else begin
				sel = $urandom_range(0, 3);
				case (sel)
					0: begin
						w = $urandom_range(0, 1500);
						b = $urandom_range(2500, SAMPLE_MAX);
						e = (w + b) / 2;
					end
					1: begin
						w = $urandom_range(2500, SAMPLE_MAX);
						b = $urandom_range(0, 1500);
						e = (w + b) / 2;
					end
					2: begin
						w = $urandom_range(0, SAMPLE_MAX);
						b = $urandom_range(0, SAMPLE_MAX);
						e = $urandom_range(0, SAMPLE_MAX);
					end
					default: begin
						w = $urandom_range(0, SAMPLE_MAX);
						b = clamp_sample(w + $urandom_range(0, 40) - 20);
						e = clamp_sample(w + $urandom_range(0, 600) - 300);
					end
				endcase
				bc = $urandom_range(0, SAMPLE_MAX);
			end
			write_all_cal(w, b, e, bc);
			repeat (5) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
				send_random(28);
			end
			drain();
		end
		tx_burst = 0;
		rx_burst = 0;
	endtask

	task automatic test_backpressure();
		tx_burst = 1;
		rx_hold_cycles = 250;
		send_random(120);
		tx_burst = 0;
		send_random(20);
		// sender waits for every result before going on
		drain();
		send_random(20);
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		line_sample <= '0;
		barcode_sample <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_calibration();
		test_empty_ranges();
		test_random_calibrations();
		test_backpressure();
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver: random stall before each transfer, or a long counted hold
	initial begin
		int w;
		out_ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				w = rx_burst ? 0 : $urandom_range(0, 15);
				if (w > 0) begin
					out_ready <= 1'b0;
					repeat (w) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_readings.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatch_count++;
			end else begin
				want = expected_readings.pop_front();
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					mismatch_count++;
				end
				if (on_edge !== want.on_edge) begin
					$error("on_edge: expected %0d, actual %0d", want.on_edge, on_edge);
					mismatch_count++;
				end
				if (region !== want.region) begin
					$error("region: expected %0d, actual %0d", want.region, region);
					mismatch_count++;
				end
				if (barcode_seen !== want.barcode_seen) begin
					$error("barcode_seen: expected %0d, actual %0d",
						want.barcode_seen, barcode_seen);
					mismatch_count++;
				end
			end
		end
	end

endmodule
